FILE: hdl/drspwm_pkg.sv
`timescale 1ns / 1ps
// Package for the dual retriggerable slow PWM block.
// Holds shared widths, reset values, register indexes and payload types; no dependencies.
package drspwm_pkg;

   localparam int CHANNELS       = 2;
   localparam int SAMPLE_BITS    = 10;
   localparam int TIME_BITS      = 22;
   localparam int CFG_BITS       = 22;
   localparam int TICK_BITS      = 8;
   localparam int DIV_BITS       = 8;
   localparam int CSR_INDEX_BITS = 3;

   // Interpolation datapath.
   localparam int PROD_BITS      = SAMPLE_BITS + TIME_BITS;
   localparam int DIV_TERMS      = (PROD_BITS - 1) / SAMPLE_BITS;
   localparam int REM_BITS       = SAMPLE_BITS + 2;
   localparam int CORR_BITS      = $clog2(DIV_TERMS + 1);
   localparam int INTERP_LATENCY = 4;
   localparam int FLIGHT_BITS    = $clog2(INTERP_LATENCY + 1);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_FULL = '1;

   // Work queue between the front and the back.
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   // Reset values.
   localparam logic [TIME_BITS-1:0] SHARED_ON_RESET  = TIME_BITS'(1000);
   localparam logic [TIME_BITS-1:0] SHARED_OFF_RESET = TIME_BITS'(300000);
   localparam logic [TIME_BITS-1:0] REMAINING_RESET  = TIME_BITS'(300000);
   localparam logic [TICK_BITS-1:0] TICK_LENGTH_RESET  = TICK_BITS'(10);
   localparam logic [TIME_BITS-1:0] ON_MIN_RESET       = TIME_BITS'(200);
   localparam logic [TIME_BITS-1:0] ON_MAX_RESET       = TIME_BITS'(4000);
   localparam logic [TIME_BITS-1:0] OFF_MIN_RESET      = TIME_BITS'(60000);
   localparam logic [TIME_BITS-1:0] OFF_MAX_RESET      = TIME_BITS'(1800000);
   localparam logic [DIV_BITS-1:0]  UPDATE_EVERY_RESET = DIV_BITS'(10);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_TICK_LENGTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_ON_MIN       = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_ON_MAX       = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFF_MIN      = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFF_MAX      = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] REG_UPDATE_EVERY = CSR_INDEX_BITS'(5);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] on_sample;
      logic [SAMPLE_BITS-1:0] off_sample;
      logic                   trigger_a_low;
      logic                   trigger_b_low;
   } req_type;

   typedef struct packed {
      logic out_a_on;
      logic out_b_on;
   } rsp_type;

   typedef struct packed {
      logic [TICK_BITS-1:0] tick_length_ms;
      logic [TIME_BITS-1:0] on_min_ms;
      logic [TIME_BITS-1:0] on_max_ms;
      logic [TIME_BITS-1:0] off_min_ms;
      logic [TIME_BITS-1:0] off_max_ms;
      logic [DIV_BITS-1:0]  update_every_ticks;
   } cfg_type;

   // One classified tick on its way to the channel update.
   typedef struct packed {
      logic                 recompute;
      logic [TIME_BITS-1:0] on_time;
      logic [TIME_BITS-1:0] off_period;
      logic [CHANNELS-1:0]  trigger;
   } work_type;

   typedef struct packed {
      logic                 recompute;
      logic [CHANNELS-1:0]  trigger;
   } flag_type;

   typedef struct packed {
      logic [QCNT_BITS-1:0] count;
   } queue_stat_type;

endpackage

FILE: hdl/drspwm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// Depends on drspwm_pkg for the payload types.
interface drspwm_req_if;
   logic                 valid;
   logic                 ready;
   drspwm_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface drspwm_rsp_if;
   logic                 valid;
   logic                 ready;
   drspwm_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/drspwm_interp.sv
`timescale 1ns / 1ps
// Four-stage pipelined interpolation t = lo +/- sample*|hi-lo|/FULL.
// Depends on drspwm_pkg; division by FULL uses a shift-sum estimate and a small correction.
module drspwm_interp (
   input  logic                               clock,
   input  logic [drspwm_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [drspwm_pkg::TIME_BITS-1:0]   lo,
   input  logic [drspwm_pkg::TIME_BITS-1:0]   hi,
   output logic [drspwm_pkg::TIME_BITS-1:0]   time_out
);

   logic [drspwm_pkg::SAMPLE_BITS-1:0] sample_s0_ff, sample_s0_in;
   logic [drspwm_pkg::TIME_BITS-1:0]   diff_s0_ff, diff_s0_in;
   logic                               down_s0_ff, down_s0_in;
   logic [drspwm_pkg::PROD_BITS-1:0]   prod_s1_ff, prod_s1_in;
   logic                               down_s1_ff;
   logic [drspwm_pkg::TIME_BITS-1:0]   quot_s2_ff, quot_s2_in;
   logic [drspwm_pkg::REM_BITS-1:0]    rem_s2_ff, rem_s2_in;
   logic                               down_s2_ff;
   logic [drspwm_pkg::TIME_BITS-1:0]   time_s3_ff, time_s3_in;

   // Stage 0: span and direction.
   always_comb begin
      sample_s0_in = sample;
      down_s0_in   = (hi < lo);
      diff_s0_in   = down_s0_in ? (lo - hi) : (hi - lo);
   end

   // Stage 1: one narrow multiply.
   assign prod_s1_in = drspwm_pkg::PROD_BITS'(sample_s0_ff)
                     * drspwm_pkg::PROD_BITS'(diff_s0_ff);

   // Stage 2: x/FULL is about the sum of x shifted right by whole sample widths.
   // The estimate never overshoots, and the remainder fits in REM_BITS bits.
   always_comb begin
      logic [drspwm_pkg::PROD_BITS-1:0] acc;
      logic [drspwm_pkg::REM_BITS-1:0]  shifted;
      acc = '0;
      for (int k = 1; k <= drspwm_pkg::DIV_TERMS; k++) begin
         acc = acc + (prod_s1_ff >> (k * drspwm_pkg::SAMPLE_BITS));
      end
      quot_s2_in = acc[drspwm_pkg::TIME_BITS-1:0];
      shifted = {quot_s2_in[drspwm_pkg::REM_BITS-drspwm_pkg::SAMPLE_BITS-1:0],
                 {drspwm_pkg::SAMPLE_BITS{1'b0}}};
      rem_s2_in = prod_s1_ff[drspwm_pkg::REM_BITS-1:0] - shifted
                + quot_s2_in[drspwm_pkg::REM_BITS-1:0];
   end

   // Stage 3: correct the quotient and apply it to the lower bound.
   always_comb begin
      logic [drspwm_pkg::CORR_BITS-1:0] corr;
      logic [drspwm_pkg::TIME_BITS-1:0] quot;
      corr = '0;
      for (int k = 1; k <= drspwm_pkg::DIV_TERMS; k++) begin
         if (int'(rem_s2_ff) >= k * int'(drspwm_pkg::SAMPLE_FULL)) begin
            corr = corr + drspwm_pkg::CORR_BITS'(1);
         end
      end
      quot = quot_s2_ff + drspwm_pkg::TIME_BITS'(corr);
      time_s3_in = down_s2_ff ? (lo - quot) : (lo + quot);
   end

   always_ff @(posedge clock) begin
      sample_s0_ff <= sample_s0_in;
      diff_s0_ff   <= diff_s0_in;
      down_s0_ff   <= down_s0_in;
      prod_s1_ff   <= prod_s1_in;
      down_s1_ff   <= down_s0_ff;
      quot_s2_ff   <= quot_s2_in;
      rem_s2_ff    <= rem_s2_in;
      down_s2_ff   <= down_s1_ff;
      time_s3_ff   <= time_s3_in;
   end

   assign time_out = time_s3_ff;

endmodule

FILE: hdl/drspwm_front.sv
`timescale 1ns / 1ps
// Front end: accepts ticks, runs the update divider and the two interpolators.
// Depends on drspwm_pkg, drspwm_if and drspwm_interp.
module drspwm_front (
   input  logic                       clock,
   input  logic                       reset,
   drspwm_req_if.sink                 req_chan,
   input  drspwm_pkg::cfg_type        cfg,
   input  drspwm_pkg::queue_stat_type queue_stat,
   output logic                       push,
   output drspwm_pkg::work_type       push_data
);

   logic                                   accept;
   logic [drspwm_pkg::FLIGHT_BITS-1:0]     in_flight;
   logic [drspwm_pkg::QCNT_BITS:0]         load;
   logic [drspwm_pkg::DIV_BITS-1:0]        div_count_ff, div_count_in, div_next;
   logic                                   first_pending_ff, first_pending_in;
   logic                                   div_hit;
   logic [drspwm_pkg::INTERP_LATENCY-1:0]  valid_ff, valid_in;
   drspwm_pkg::flag_type                   flag_ff [drspwm_pkg::INTERP_LATENCY];
   drspwm_pkg::flag_type                   flag_in;
   logic [drspwm_pkg::TIME_BITS-1:0]       on_time, off_period;

   // Every item in the interpolators has a queue slot waiting for it.
   assign in_flight = drspwm_pkg::FLIGHT_BITS'($countones(valid_ff));
   assign load = (drspwm_pkg::QCNT_BITS + 1)'(queue_stat.count)
               + (drspwm_pkg::QCNT_BITS + 1)'(in_flight);
   assign req_chan.ready = (load < (drspwm_pkg::QCNT_BITS + 1)'(drspwm_pkg::QUEUE_DEPTH));
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      div_next         = div_count_ff + drspwm_pkg::DIV_BITS'(1);
      div_hit          = (div_next >= cfg.update_every_ticks);
      div_count_in     = div_count_ff;
      first_pending_in = first_pending_ff;
      if (accept) begin
         div_count_in     = div_hit ? '0 : div_next;
         first_pending_in = 1'b0;
      end
      flag_in.recompute = first_pending_ff || div_hit;
      flag_in.trigger   = {req_chan.data.trigger_b_low, req_chan.data.trigger_a_low};
      valid_in = {valid_ff[drspwm_pkg::INTERP_LATENCY-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_count_ff     <= '0;
         first_pending_ff <= 1'b1;
         valid_ff         <= '0;
      end else begin
         div_count_ff     <= div_count_in;
         first_pending_ff <= first_pending_in;
         valid_ff         <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flag_ff[0] <= flag_in;
      for (int i = 1; i < drspwm_pkg::INTERP_LATENCY; i++) begin
         flag_ff[i] <= flag_ff[i-1];
      end
   end

   drspwm_interp u_on_interp (
      .clock    (clock),
      .sample   (req_chan.data.on_sample),
      .lo       (cfg.on_min_ms),
      .hi       (cfg.on_max_ms),
      .time_out (on_time)
   );

   drspwm_interp u_off_interp (
      .clock    (clock),
      .sample   (req_chan.data.off_sample),
      .lo       (cfg.off_min_ms),
      .hi       (cfg.off_max_ms),
      .time_out (off_period)
   );

   assign push                 = valid_ff[drspwm_pkg::INTERP_LATENCY-1];
   assign push_data.recompute  = flag_ff[drspwm_pkg::INTERP_LATENCY-1].recompute;
   assign push_data.trigger    = flag_ff[drspwm_pkg::INTERP_LATENCY-1].trigger;
   assign push_data.on_time    = on_time;
   assign push_data.off_period = off_period;

   // The first-tick recompute is consumed only by an accepted transaction.
   assert property (@(posedge clock) disable iff (reset)
      $fell(first_pending_ff) |-> $past(accept))
      else $error("first-tick recompute flag cleared without a transaction");

endmodule

FILE: hdl/drspwm_queue.sv
`timescale 1ns / 1ps
// Short work queue between the front end and the channel update.
// Depends on drspwm_pkg.
module drspwm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  drspwm_pkg::work_type       push_data,
   input  logic                       pop,
   output logic                       head_valid,
   output drspwm_pkg::work_type       head,
   output drspwm_pkg::queue_stat_type queue_stat
);

   drspwm_pkg::work_type             entry_ff [drspwm_pkg::QUEUE_DEPTH];
   logic [drspwm_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [drspwm_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [drspwm_pkg::QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + drspwm_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + drspwm_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + drspwm_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - drspwm_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid       = (count_ff != '0);
   assign head             = entry_ff[rd_ptr_ff];
   assign queue_stat.count = count_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= drspwm_pkg::QCNT_BITS'(drspwm_pkg::QUEUE_DEPTH))
      else $error("work queue count beyond its depth");

   assert property (@(posedge clock) disable iff (reset)
      !(push && (count_ff == drspwm_pkg::QCNT_BITS'(drspwm_pkg::QUEUE_DEPTH))))
      else $error("work queue written while full");

endmodule

FILE: hdl/drspwm_back.sv
`timescale 1ns / 1ps
// Back end: per-channel clamp, trigger and countdown, with the response register.
// Depends on drspwm_pkg and drspwm_if.
module drspwm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  drspwm_pkg::work_type              head,
   output logic                              pop,
   input  logic [drspwm_pkg::TICK_BITS-1:0]  tick_length_ms,
   drspwm_rsp_if.source                      rsp_chan
);

   logic [drspwm_pkg::TIME_BITS-1:0] shared_on_ff, shared_on_in;
   logic [drspwm_pkg::TIME_BITS-1:0] shared_off_ff, shared_off_in;
   logic [drspwm_pkg::TIME_BITS-1:0] remaining_ff [drspwm_pkg::CHANNELS];
   logic [drspwm_pkg::TIME_BITS-1:0] remaining_in [drspwm_pkg::CHANNELS];
   logic [drspwm_pkg::CHANNELS-1:0]  phase_ff, phase_in;
   logic [drspwm_pkg::CHANNELS-1:0]  held_ff, held_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   drspwm_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   assign pop = head_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      logic [drspwm_pkg::TIME_BITS-1:0] rem;
      logic [drspwm_pkg::TIME_BITS-1:0] limit;
      logic [drspwm_pkg::TIME_BITS-1:0] tick;
      logic                             ph;
      tick          = drspwm_pkg::TIME_BITS'(tick_length_ms);
      shared_on_in  = shared_on_ff;
      shared_off_in = shared_off_ff;
      phase_in      = phase_ff;
      held_in       = held_ff;
      for (int c = 0; c < drspwm_pkg::CHANNELS; c++) begin
         remaining_in[c] = remaining_ff[c];
      end
      if (pop && head.recompute) begin
         shared_on_in  = head.on_time;
         shared_off_in = head.off_period;
      end
      for (int c = 0; c < drspwm_pkg::CHANNELS; c++) begin
         rem   = remaining_ff[c];
         ph    = phase_ff[c];
         limit = ph ? head.on_time : head.off_period;
         // A recompute shortens the current phase to its new length.
         if (head.recompute) begin
            if (rem > limit) begin
               rem = limit;
            end
         end
         // A newly asserted trigger restarts the on phase.
         if (head.trigger[c]) begin
            if (!held_ff[c]) begin
               ph  = 1'b1;
               rem = shared_on_in;
            end
         end
         if (rem > tick) begin
            rem = rem - tick;
         end else if (!ph) begin
            ph  = 1'b1;
            rem = shared_on_in;
         end else begin
            ph  = 1'b0;
            rem = shared_off_in;
         end
         if (pop) begin
            remaining_in[c] = rem;
            phase_in[c]     = ph;
            held_in[c]      = head.trigger[c];
         end
      end
      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_data_in.out_a_on = phase_in[0];
         rsp_data_in.out_b_on = phase_in[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shared_on_ff  <= drspwm_pkg::SHARED_ON_RESET;
         shared_off_ff <= drspwm_pkg::SHARED_OFF_RESET;
         phase_ff      <= '0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < drspwm_pkg::CHANNELS; c++) begin
            remaining_ff[c] <= drspwm_pkg::REMAINING_RESET;
         end
      end else begin
         shared_on_ff  <= shared_on_in;
         shared_off_ff <= shared_off_in;
         phase_ff      <= phase_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int c = 0; c < drspwm_pkg::CHANNELS; c++) begin
            remaining_ff[c] <= remaining_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // The time left in a phase never exceeds that phase's shared length.
   for (genvar c = 0; c < drspwm_pkg::CHANNELS; c++) begin : g_check
      assert property (@(posedge clock) disable iff (reset)
         remaining_ff[c] <= (phase_ff[c] ? shared_on_ff : shared_off_ff))
         else $error("channel remaining time exceeds its phase length");
   end

endmodule

FILE: hdl/dual_retriggerable_slow_pwm.sv
`timescale 1ns / 1ps
// Top level of the dual retriggerable slow PWM block: configuration registers and wiring.
// Depends on drspwm_pkg, drspwm_if, drspwm_front, drspwm_queue and drspwm_back.
//
// Each request transaction is one scheduler tick carrying the on and off control samples and the
// two active-low trigger levels; each tick yields exactly one response transaction with both
// channel levels after that tick. On the first tick after reset and then whenever the update
// divider reaches update_every_ticks, the shared on and off times are re-interpolated from the
// tick's samples, and each channel's remaining time is clamped to its current phase length. A
// newly asserted trigger forces its channel on with the full on time; every channel then counts
// down by tick_length_ms or switches phase. The block takes one tick per clock cycle while
// request ready is high. An accepted tick passes through the four pipelined interpolator stages
// (span, multiply, quotient estimate, correction), is written into the work queue and then
// loads the response register of the channel update; the queue lets the next tick be accepted
// while a result waits. The work queue holds eight ticks, and request ready falls only when the
// queue plus the interpolators hold eight transactions. Configuration writes take effect at once
// and are meant to be made while no transaction is outstanding.
module dual_retriggerable_slow_pwm (
   input  logic                                  clock,
   input  logic                                  reset,
   drspwm_req_if.sink                            req_chan,
   drspwm_rsp_if.source                          rsp_chan,
   input  logic                                  csr_we,
   input  logic [drspwm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [drspwm_pkg::CFG_BITS-1:0]       csr_wdata
);

   drspwm_pkg::cfg_type        cfg_ff, cfg_in;
   drspwm_pkg::queue_stat_type queue_stat;
   drspwm_pkg::work_type       push_data;
   drspwm_pkg::work_type       head;
   logic                       push;
   logic                       pop;
   logic                       head_valid;

   // Register writes; an index beyond the list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            drspwm_pkg::REG_TICK_LENGTH: begin
               cfg_in.tick_length_ms = csr_wdata[drspwm_pkg::TICK_BITS-1:0];
            end
            drspwm_pkg::REG_ON_MIN: begin
               cfg_in.on_min_ms = csr_wdata[drspwm_pkg::TIME_BITS-1:0];
            end
            drspwm_pkg::REG_ON_MAX: begin
               cfg_in.on_max_ms = csr_wdata[drspwm_pkg::TIME_BITS-1:0];
            end
            drspwm_pkg::REG_OFF_MIN: begin
               cfg_in.off_min_ms = csr_wdata[drspwm_pkg::TIME_BITS-1:0];
            end
            drspwm_pkg::REG_OFF_MAX: begin
               cfg_in.off_max_ms = csr_wdata[drspwm_pkg::TIME_BITS-1:0];
            end
            drspwm_pkg::REG_UPDATE_EVERY: begin
               cfg_in.update_every_ticks = csr_wdata[drspwm_pkg::DIV_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_length_ms     <= drspwm_pkg::TICK_LENGTH_RESET;
         cfg_ff.on_min_ms          <= drspwm_pkg::ON_MIN_RESET;
         cfg_ff.on_max_ms          <= drspwm_pkg::ON_MAX_RESET;
         cfg_ff.off_min_ms         <= drspwm_pkg::OFF_MIN_RESET;
         cfg_ff.off_max_ms         <= drspwm_pkg::OFF_MAX_RESET;
         cfg_ff.update_every_ticks <= drspwm_pkg::UPDATE_EVERY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: divider, recompute decision and interpolation of both times.
   drspwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .queue_stat (queue_stat),
      .push       (push),
      .push_data  (push_data)
   );

   // Work queue that lets the two halves stall independently.
   drspwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .queue_stat (queue_stat)
   );

   // Back end: channel state and the response register.
   drspwm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop),
      .tick_length_ms (cfg_ff.tick_length_ms),
      .rsp_chan       (rsp_chan)
   );

endmodule
